@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the timestamp parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error(msg);

`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error(msg);

`else

`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg)

`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

@@ hw/rtl/iso2ep_pkg.sv @@
// Types, constants and lookup functions of the timestamp to epoch parser.
package iso2ep_pkg;

    localparam int MAX_FRAC_DIGITS_DEF = 9;
    localparam int FIXED_LEN           = 19;

    localparam logic [13:0] MIN_YEAR_RESET = 14'd2024;
    localparam logic [13:0] EPOCH_YEAR     = 14'd1970;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Conversion constants.
    localparam int DIV25_MUL_YEAR   = 1311;   // (n >> 4) * this >> 15 == n / 400
    localparam int DIV25_SH_YEAR    = 15;
    localparam int DIV25_MUL_YOE    = 164;    // (n >> 2) * this >> 12 == n / 100
    localparam int DIV25_SH_YOE     = 12;
    localparam int DAYS_PER_ERA     = 146097;
    localparam int DAYS_TO_EPOCH    = 719468;
    localparam int SEC_PER_DAY      = 86400;
    localparam logic [37:0] EPOCH_MAX = 38'd253402300800;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_AFTER_SEC,
        PH_DOT,
        PH_FRAC,
        PH_AFTER_Z
    } phase_t;

    typedef enum logic [2:0] {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND
    } field_t;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        frac_nz;
        logic        parse_ok;
    } fields_t;

    // Separator expected at a fixed position, or NUL where a digit belongs.
    function automatic logic [7:0] sep_at(input logic [4:0] pos);
        logic [7:0] sep;
        case (pos)
            5'd4, 5'd7:   sep = CH_DASH;
            5'd10:        sep = CH_T;
            5'd13, 5'd16: sep = CH_COLON;
            default:      sep = CH_NUL;
        endcase
        return sep;
    endfunction

    function automatic field_t field_at(input logic [4:0] pos);
        field_t fld;
        case (pos)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4: fld = FLD_YEAR;
            5'd5, 5'd6, 5'd7:             fld = FLD_MONTH;
            5'd8, 5'd9, 5'd10:            fld = FLD_DAY;
            5'd11, 5'd12, 5'd13:          fld = FLD_HOUR;
            5'd14, 5'd15, 5'd16:          fld = FLD_MINUTE;
            default:                      fld = FLD_SECOND;
        endcase
        return fld;
    endfunction

    // Day of the March-based year on which each shifted month starts.
    function automatic logic [8:0] doy_base(input logic [3:0] mp);
        logic [8:0] base;
        case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

    function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            7'd2:                      days = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

@@ hw/rtl/iso2ep_parser.sv @@
// Character parser: field accumulators, parse phase and the capture register.
`include "assert_macros.svh"

module iso2ep_parser #(
    parameter int MAX_FRACTION_DIGITS = iso2ep_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          char_code,
    input  logic                last,
    output logic                cap_valid,
    input  logic                cap_ready,
    output iso2ep_pkg::fields_t cap_fields
);

    localparam int FracW = $clog2(MAX_FRACTION_DIGITS + 1);

    logic [4:0]         pos_reg, pos_next;
    logic [13:0]        year_reg, year_next;
    logic [6:0]         month_reg, month_next;
    logic [6:0]         day_reg, day_next;
    logic [6:0]         hour_reg, hour_next;
    logic [6:0]         minute_reg, minute_next;
    logic [6:0]         second_reg, second_next;
    logic [FracW-1:0]   frac_cnt_reg, frac_cnt_next;
    logic               frac_nz_reg, frac_nz_next;
    iso2ep_pkg::phase_t phase_reg, phase_next;
    logic               failed_reg, failed_next;
    logic               ended_reg, ended_next;
    logic               cap_valid_reg, cap_valid_next;
    iso2ep_pkg::fields_t cap_reg, cap_next;

    // Values after the current character is taken, before the end-of-text clear.
    logic [4:0]         a_pos;
    logic [13:0]        a_year;
    logic [6:0]         a_month, a_day, a_hour, a_minute, a_second;
    logic [FracW-1:0]   a_frac_cnt;
    logic               a_frac_nz;
    iso2ep_pkg::phase_t a_phase;
    logic               a_failed, a_ended;

    logic               accept;
    logic               cap_load;
    logic               is_digit;
    logic [3:0]         digit;
    logic [7:0]         sep;
    logic [13:0]        year_acc;
    logic [6:0]         month_acc, day_acc, hour_acc, minute_acc, second_acc;

    assign in_stall   = last & cap_valid_reg & ~cap_ready;
    assign accept     = in_valid & ~in_stall;
    assign cap_load   = accept & last & (~cap_valid_reg | cap_ready);
    assign cap_valid  = cap_valid_reg;
    assign cap_fields = cap_reg;

    assign is_digit   = (char_code >= iso2ep_pkg::CH_DIG0) && (char_code <= iso2ep_pkg::CH_DIG9);
    assign digit      = char_code[3:0];
    assign sep        = iso2ep_pkg::sep_at(pos_reg);

    // Decimal shift-in: acc * 10 + digit, kept to the field width.
    assign year_acc   = (year_reg << 3) + (year_reg << 1) + {10'd0, digit};
    assign month_acc  = (month_reg << 3) + (month_reg << 1) + {3'd0, digit};
    assign day_acc    = (day_reg << 3) + (day_reg << 1) + {3'd0, digit};
    assign hour_acc   = (hour_reg << 3) + (hour_reg << 1) + {3'd0, digit};
    assign minute_acc = (minute_reg << 3) + (minute_reg << 1) + {3'd0, digit};
    assign second_acc = (second_reg << 3) + (second_reg << 1) + {3'd0, digit};

    always_comb
    begin
        a_pos      = pos_reg;
        a_year     = year_reg;
        a_month    = month_reg;
        a_day      = day_reg;
        a_hour     = hour_reg;
        a_minute   = minute_reg;
        a_second   = second_reg;
        a_frac_cnt = frac_cnt_reg;
        a_frac_nz  = frac_nz_reg;
        a_phase    = phase_reg;
        a_failed   = failed_reg;
        a_ended    = ended_reg;

        if (!ended_reg)
        begin
            if (char_code == iso2ep_pkg::CH_NUL)
            begin
                a_ended = 1'b1;
            end
            else if (!failed_reg)
            begin
                case (phase_reg)
                    iso2ep_pkg::PH_FIXED:
                    begin
                        if (sep != iso2ep_pkg::CH_NUL)
                        begin
                            if (char_code != sep)
                            begin
                                a_failed = 1'b1;
                            end
                        end
                        else if (!is_digit)
                        begin
                            a_failed = 1'b1;
                        end
                        else
                        begin
                            case (iso2ep_pkg::field_at(pos_reg))
                                iso2ep_pkg::FLD_YEAR:   a_year   = year_acc;
                                iso2ep_pkg::FLD_MONTH:  a_month  = month_acc;
                                iso2ep_pkg::FLD_DAY:    a_day    = day_acc;
                                iso2ep_pkg::FLD_HOUR:   a_hour   = hour_acc;
                                iso2ep_pkg::FLD_MINUTE: a_minute = minute_acc;
                                default:                a_second = second_acc;
                            endcase
                        end
                        if (pos_reg == 5'(iso2ep_pkg::FIXED_LEN - 1))
                        begin
                            a_phase = iso2ep_pkg::PH_AFTER_SEC;
                        end
                        else
                        begin
                            a_pos = pos_reg + 5'd1;
                        end
                    end
                    iso2ep_pkg::PH_AFTER_SEC:
                    begin
                        if (char_code == iso2ep_pkg::CH_DOT)
                        begin
                            a_phase = iso2ep_pkg::PH_DOT;
                        end
                        else if (char_code == iso2ep_pkg::CH_Z)
                        begin
                            a_phase = iso2ep_pkg::PH_AFTER_Z;
                        end
                        else
                        begin
                            a_failed = 1'b1;
                        end
                    end
                    iso2ep_pkg::PH_DOT, iso2ep_pkg::PH_FRAC:
                    begin
                        if (is_digit)
                        begin
                            if (frac_cnt_reg >= FracW'(MAX_FRACTION_DIGITS))
                            begin
                                a_failed = 1'b1;
                            end
                            else
                            begin
                                a_frac_cnt = frac_cnt_reg + FracW'(1);
                                if (char_code != iso2ep_pkg::CH_DIG0)
                                begin
                                    a_frac_nz = 1'b1;
                                end
                                a_phase = iso2ep_pkg::PH_FRAC;
                            end
                        end
                        else if (char_code == iso2ep_pkg::CH_Z &&
                                 phase_reg == iso2ep_pkg::PH_FRAC)
                        begin
                            a_phase = iso2ep_pkg::PH_AFTER_Z;
                        end
                        else
                        begin
                            a_failed = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Anything after Z spoils the text.
                        a_failed = 1'b1;
                    end
                endcase
            end
        end

        // Register next values: the word marked last clears the parse state.
        pos_next      = pos_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        frac_cnt_next = frac_cnt_reg;
        frac_nz_next  = frac_nz_reg;
        phase_next    = phase_reg;
        failed_next   = failed_reg;
        ended_next    = ended_reg;
        if (accept)
        begin
            if (last)
            begin
                pos_next      = '0;
                year_next     = '0;
                month_next    = '0;
                day_next      = '0;
                hour_next     = '0;
                minute_next   = '0;
                second_next   = '0;
                frac_cnt_next = '0;
                frac_nz_next  = 1'b0;
                phase_next    = iso2ep_pkg::PH_FIXED;
                failed_next   = 1'b0;
                ended_next    = 1'b0;
            end
            else
            begin
                pos_next      = a_pos;
                year_next     = a_year;
                month_next    = a_month;
                day_next      = a_day;
                hour_next     = a_hour;
                minute_next   = a_minute;
                second_next   = a_second;
                frac_cnt_next = a_frac_cnt;
                frac_nz_next  = a_frac_nz;
                phase_next    = a_phase;
                failed_next   = a_failed;
                ended_next    = a_ended;
            end
        end

        cap_valid_next = cap_valid_reg;
        if (!cap_valid_reg || cap_ready)
        begin
            cap_valid_next = accept & last;
        end

        cap_next.year     = a_year;
        cap_next.month    = a_month;
        cap_next.day      = a_day;
        cap_next.hour     = a_hour;
        cap_next.minute   = a_minute;
        cap_next.second   = a_second;
        cap_next.frac_nz  = a_frac_nz;
        cap_next.parse_ok = ~a_failed & (a_phase == iso2ep_pkg::PH_AFTER_Z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            frac_cnt_reg  <= '0;
            frac_nz_reg   <= 1'b0;
            phase_reg     <= iso2ep_pkg::PH_FIXED;
            failed_reg    <= 1'b0;
            ended_reg     <= 1'b0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            frac_cnt_reg  <= frac_cnt_next;
            frac_nz_reg   <= frac_nz_next;
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            ended_reg     <= ended_next;
            cap_valid_reg <= cap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_load)
        begin
            cap_reg <= cap_next;
        end
    end

    `ASSERT_CLK(a_pos_range, clk, rst_n, phase_reg == iso2ep_pkg::PH_FIXED |-> pos_reg < 5'(iso2ep_pkg::FIXED_LEN), "fixed field position out of range")
    `ASSERT_NEVER(a_frac_bound, clk, rst_n, frac_cnt_reg > FracW'(MAX_FRACTION_DIGITS), "fraction count beyond limit")
    `ASSERT_CLK(a_frac_seen, clk, rst_n, phase_reg == iso2ep_pkg::PH_FRAC |-> frac_cnt_reg != '0, "fraction phase without digits")
    `ASSERT_CLK(a_cap_hold, clk, rst_n, cap_valid_reg && !cap_ready |=> cap_valid_reg, "captured text dropped while blocked")

endmodule

@@ hw/rtl/iso2ep_convert.sv @@
// Five-stage pipeline from captured date and time fields to epoch seconds.
`include "assert_macros.svh"

module iso2ep_convert (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [13:0]         min_year,
    input  logic                cap_valid,
    output logic                cap_ready,
    input  iso2ep_pkg::fields_t cap_fields,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [37:0]         epoch_seconds,
    output logic                valid_res
);

    // Stage valid bits and ready chain; a stage takes new data when it is
    // empty or its contents move on in the same cycle.
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, out_valid_reg;
    logic rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6      = ~out_valid_reg | ~out_stall;
    assign rdy5      = ~s5_valid_reg | rdy6;
    assign rdy4      = ~s4_valid_reg | rdy5;
    assign rdy3      = ~s3_valid_reg | rdy4;
    assign rdy2      = ~s2_valid_reg | rdy3;
    assign cap_ready = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy2) s2_valid_reg  <= cap_valid;
            if (rdy3) s3_valid_reg  <= s2_valid_reg;
            if (rdy4) s4_valid_reg  <= s3_valid_reg;
            if (rdy5) s5_valid_reg  <= s4_valid_reg;
            if (rdy6) out_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 2: range checks, year / 400, shifted month.
    logic [20:0] q_prod;
    logic [6:0]  mp_full;
    logic        ok2_next;
    logic [13:0] s2_year_reg;
    logic [6:0]  s2_month_reg, s2_day_reg, s2_hour_reg, s2_minute_reg, s2_second_reg;
    logic        s2_frac_nz_reg, s2_ok_reg;
    logic [5:0]  s2_q400_reg;
    logic [8:0]  s2_doy_base_reg;

    assign q_prod  = 21'(cap_fields.year[13:4]) * 21'(iso2ep_pkg::DIV25_MUL_YEAR);
    assign mp_full = (cap_fields.month > 7'd2) ? (cap_fields.month - 7'd3)
                                               : (cap_fields.month + 7'd9);
    assign ok2_next = cap_fields.parse_ok &&
                      (cap_fields.year >= min_year) &&
                      (cap_fields.year >= iso2ep_pkg::EPOCH_YEAR) &&
                      (cap_fields.month >= 7'd1) && (cap_fields.month <= 7'd12) &&
                      (cap_fields.day >= 7'd1) &&
                      (cap_fields.hour <= 7'd23) &&
                      (cap_fields.minute <= 7'd59) &&
                      (cap_fields.second <= 7'd59);

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_year_reg     <= cap_fields.year;
            s2_month_reg    <= cap_fields.month;
            s2_day_reg      <= cap_fields.day;
            s2_hour_reg     <= cap_fields.hour;
            s2_minute_reg   <= cap_fields.minute;
            s2_second_reg   <= cap_fields.second;
            s2_frac_nz_reg  <= cap_fields.frac_nz;
            s2_ok_reg       <= ok2_next;
            s2_q400_reg     <= q_prod[iso2ep_pkg::DIV25_SH_YEAR +: 6];
            s2_doy_base_reg <= iso2ep_pkg::doy_base(mp_full[3:0]);
        end
    end

    // Stage 3: year within its 400-year cycle, leap check, day of year,
    // seconds within the day.
    logic [13:0] prod400, r_full;
    logic [8:0]  r400;
    logic        leap, early;
    logic [4:0]  mdays;
    logic [9:0]  doy_full;
    logic [16:0] hms_next;
    logic        ok3_next;
    logic [5:0]  era_next;
    logic [8:0]  yoe_next;
    logic        s3_ok_reg;
    logic [5:0]  s3_era_reg;
    logic [8:0]  s3_yoe_reg, s3_doy_reg;
    logic [16:0] s3_hms_reg;

    assign prod400  = 14'(s2_q400_reg) * 14'd400;
    assign r_full   = s2_year_reg - prod400;
    assign r400     = r_full[8:0];
    assign leap     = (r400[1:0] == 2'd0) && (r400 != 9'd100) &&
                      (r400 != 9'd200) && (r400 != 9'd300);
    assign mdays    = iso2ep_pkg::month_days(s2_month_reg, leap);
    assign ok3_next = s2_ok_reg && (s2_day_reg <= {2'd0, mdays});
    assign early    = s2_month_reg <= 7'd2;
    // January and February count toward the previous year.
    assign era_next = (early && r400 == 9'd0) ? (s2_q400_reg - 6'd1) : s2_q400_reg;
    assign yoe_next = early ? ((r400 == 9'd0) ? 9'd399 : (r400 - 9'd1)) : r400;
    assign doy_full = {1'b0, s2_doy_base_reg} + {3'd0, s2_day_reg} - 10'd1;
    assign hms_next = 17'(s2_hour_reg) * 17'd3600 + 17'(s2_minute_reg) * 17'd60 +
                      17'(s2_second_reg) + 17'(s2_frac_nz_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_ok_reg  <= ok3_next;
            s3_era_reg <= era_next;
            s3_yoe_reg <= yoe_next;
            s3_doy_reg <= doy_full[8:0];
            s3_hms_reg <= hms_next;
        end
    end

    // Stage 4: day of era and days of the whole eras.
    logic [17:0] yoe365, doe_next;
    logic [6:0]  yq;
    logic [14:0] c_prod;
    logic [2:0]  cent;
    logic [22:0] era_days_next;
    logic        s4_ok_reg;
    logic [22:0] s4_era_days_reg;
    logic [17:0] s4_doe_reg;
    logic [16:0] s4_hms_reg;

    assign yoe365        = 18'(s3_yoe_reg) * 18'd365;
    assign yq            = s3_yoe_reg[8:2];
    assign c_prod        = 15'(yq) * 15'(iso2ep_pkg::DIV25_MUL_YOE);
    assign cent          = c_prod[iso2ep_pkg::DIV25_SH_YOE +: 3];
    assign doe_next      = yoe365 + 18'(yq) - 18'(cent) + 18'(s3_doy_reg);
    assign era_days_next = 23'(s3_era_reg) * 23'(iso2ep_pkg::DAYS_PER_ERA);

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_ok_reg       <= s3_ok_reg;
            s4_era_days_reg <= era_days_next;
            s4_doe_reg      <= doe_next;
            s4_hms_reg      <= s3_hms_reg;
        end
    end

    // Stage 5: days since the epoch.
    logic [23:0] days_full;
    logic        s5_ok_reg;
    logic [21:0] s5_days_reg;
    logic [16:0] s5_hms_reg;

    assign days_full = 24'(s4_era_days_reg) + 24'(s4_doe_reg) -
                       24'(iso2ep_pkg::DAYS_TO_EPOCH);

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            s5_ok_reg   <= s4_ok_reg;
            s5_days_reg <= days_full[21:0];
            s5_hms_reg  <= s4_hms_reg;
        end
    end

    // Output stage: seconds, forced to zero for a rejected text.
    logic [38:0] secs_full;
    logic [37:0] epoch_reg;
    logic        valid_res_reg;

    assign secs_full = 39'(s5_days_reg) * 39'(iso2ep_pkg::SEC_PER_DAY) + 39'(s5_hms_reg);

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            epoch_reg     <= s5_ok_reg ? secs_full[37:0] : 38'd0;
            valid_res_reg <= s5_ok_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign valid_res     = valid_res_reg;

    `ASSERT_CLK(a_s2_hold, clk, rst_n, s2_valid_reg && !rdy2 |=> s2_valid_reg, "stage 2 word lost under stall")
    `ASSERT_CLK(a_s5_hold, clk, rst_n, s5_valid_reg && !rdy5 |=> s5_valid_reg, "stage 5 word lost under stall")
    `ASSERT_NEVER(a_epoch_max, clk, rst_n, out_valid_reg && valid_res_reg && epoch_reg > iso2ep_pkg::EPOCH_MAX, "epoch beyond year 9999")

endmodule

@@ hw/rtl/iso8601_utc_to_epoch_parser_top.sv @@
// Top level of the ISO 8601 UTC timestamp to Unix epoch parser.
//
// Input channel (in_valid / in_stall): one word per character, char_code and
// last. A word is taken at a clock edge with in_valid high and in_stall low.
// Characters are taken one per cycle unless in_stall is high; the next text
// may start in the cycle right after a word marked last.
// Output channel (out_valid / out_stall): one word per text, epoch_seconds
// and valid_res; the word marked last passes the capture register, stages 2
// to 5 and the output stage before its result appears on the outputs. A word
// is taken when out_valid is high and out_stall is low.
// Throughput is one character per cycle while in_stall is low; the
// conversion pipeline holds up to five texts in flight.
// While the receiver stalls, the pipeline fills; in_stall rises only for a
// word marked last that finds the capture register still occupied.
// Configuration (cfg_valid / cfg_ready): cfg_data sets the minimum accepted
// year. cfg_ready is always high. Write it only while no text is in flight.
// Reset clears the parse state and the pipeline and sets the minimum year
// to 2024; no results are pending afterwards.
module iso8601_utc_to_epoch_parser_top #(
    parameter int MAX_FRACTION_DIGITS = iso2ep_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [37:0] epoch_seconds,
    output logic        valid_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data
);

    logic [13:0]         min_year_reg, min_year_next;
    logic                cap_valid, cap_ready;
    iso2ep_pkg::fields_t cap_fields;

    assign cfg_ready     = 1'b1;
    assign min_year_next = (cfg_valid && cfg_ready) ? cfg_data : min_year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= iso2ep_pkg::MIN_YEAR_RESET;
        end
        else
        begin
            min_year_reg <= min_year_next;
        end
    end

    iso2ep_parser #(
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .last       (last),
        .cap_valid  (cap_valid),
        .cap_ready  (cap_ready),
        .cap_fields (cap_fields)
    );

    iso2ep_convert u_convert (
        .clk           (clk),
        .rst_n         (rst_n),
        .min_year      (min_year_reg),
        .cap_valid     (cap_valid),
        .cap_ready     (cap_ready),
        .cap_fields    (cap_fields),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .epoch_seconds (epoch_seconds),
        .valid_res     (valid_res)
    );

endmodule

@@ dv/tb_iso8601_utc_to_epoch_parser_top.sv @@
// Self-checking testbench for the ISO 8601 timestamp to epoch seconds parser.
`timescale 1ns / 1ps

module tb_iso8601_utc_to_epoch_parser_top;
    import iso2ep_pkg::*;

    localparam int PIPE_LATENCY = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int GAP_PERCENT  = 11;

    // Separator expected at each fixed position; NUL marks a digit position.
    localparam logic [7:0] SEP_MAP [0:18] = '{
        CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_DASH, CH_NUL, CH_NUL, CH_DASH, CH_NUL, CH_NUL,
        CH_T, CH_NUL, CH_NUL, CH_COLON, CH_NUL, CH_NUL, CH_COLON, CH_NUL, CH_NUL
    };

    typedef struct packed {
        logic [4:0]  pos;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [3:0]  frac_digits;
        logic        frac_nz;
        logic        bad;
        logic        ended;
        phase_t      phase;
    } scan_t;

    typedef struct packed {
        logic [37:0] epoch;
        logic        ok;
    } stamp_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [37:0] epoch_seconds;
    logic        valid_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data = 14'd0;

    logic [13:0] min_year_now = MIN_YEAR_RESET;
    scan_t       scan = '0;
    stamp_t      pending_stamps [$];
    logic [7:0]  text_buf [$];
    bit          gaps_on = 1'b1;
    int          hold_left = 0;
    int          mismatches = 0;
    int          chars_sent = 0;
    int          quiet_cycles = 0;

    iso8601_utc_to_epoch_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .epoch_seconds (epoch_seconds),
        .valid_res     (valid_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int month_length(int y, int m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m == 2)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Advances the expected parse state by one accepted character.
    task automatic scan_char(input logic [7:0] c);
        logic [7:0] dig;
        bit         is_dig;
        dig = c - CH_DIG0;
        is_dig = (c >= CH_DIG0) && (c <= CH_DIG9);
        if (c == CH_NUL)
            scan.ended = 1'b1;
        else if (!scan.bad)
        begin
            case (scan.phase)
                PH_FIXED:
                begin
                    if (SEP_MAP[scan.pos] != CH_NUL)
                    begin
                        if (c != SEP_MAP[scan.pos])
                            scan.bad = 1'b1;
                    end
                    else if (!is_dig)
                        scan.bad = 1'b1;
                    else if (scan.pos < 4)
                        scan.year = 14'(scan.year * 10 + dig);
                    else if (scan.pos < 7)
                        scan.month = 7'(scan.month * 10 + dig);
                    else if (scan.pos < 10)
                        scan.day = 7'(scan.day * 10 + dig);
                    else if (scan.pos < 13)
                        scan.hour = 7'(scan.hour * 10 + dig);
                    else if (scan.pos < 16)
                        scan.minute = 7'(scan.minute * 10 + dig);
                    else
                        scan.second = 7'(scan.second * 10 + dig);
                    if (scan.pos == 5'd18)
                        scan.phase = PH_AFTER_SEC;
                    else
                        scan.pos = scan.pos + 5'd1;
                end
                PH_AFTER_SEC:
                begin
                    if (c == CH_DOT)
                        scan.phase = PH_DOT;
                    else if (c == CH_Z)
                        scan.phase = PH_AFTER_Z;
                    else
                        scan.bad = 1'b1;
                end
                PH_DOT, PH_FRAC:
                begin
                    if (is_dig)
                    begin
                        if (scan.frac_digits >= MAX_FRAC_DIGITS_DEF)
                            scan.bad = 1'b1;
                        else
                        begin
                            scan.frac_digits = scan.frac_digits + 4'd1;
                            if (c != CH_DIG0)
                                scan.frac_nz = 1'b1;
                            scan.phase = PH_FRAC;
                        end
                    end
                    else if (c == CH_Z && scan.phase == PH_FRAC)
                        scan.phase = PH_AFTER_Z;
                    else
                        scan.bad = 1'b1;
                end
                default:
                    scan.bad = 1'b1;
            endcase
        end
    endtask

    // Closes the text: computes the expected word and clears the parse state.
    task automatic convert_stamp();
        stamp_t  want;
        longint  y, m, d, yy, era, yoe, mp, doy, doe, days;
        want = '0;
        y = scan.year;
        m = scan.month;
        d = scan.day;
        if (!scan.bad && scan.phase == PH_AFTER_Z && y >= min_year_now && y >= EPOCH_YEAR
            && m >= 1 && m <= 12 && d >= 1 && d <= month_length(int'(y), int'(m))
            && scan.hour <= 23 && scan.minute <= 59 && scan.second <= 59)
        begin
            // Day count with the year starting in March, so February comes last.
            yy = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            mp = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * DAYS_PER_ERA + doe - DAYS_TO_EPOCH;
            want.epoch = 38'(days * SEC_PER_DAY + longint'(scan.hour) * 3600
                             + longint'(scan.minute) * 60 + longint'(scan.second)
                             + longint'(scan.frac_nz));
            want.ok = 1'b1;
        end
        pending_stamps.push_back(want);
        scan = '0;
        scan.phase = PH_FIXED;
    endtask

    task automatic send_char(input logic [7:0] c, input logic fin);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        last <= fin;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
        if (!scan.ended)
            scan_char(c);
        if (fin)
            convert_stamp();
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_min_year(input logic [13:0] yr);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= yr;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_year_now = yr;
    endtask

    function automatic string frac_text(int n, bit zeros);
        string f;
        f = (n > 0) ? "." : "";
        for (int i = 0; i < n; i++)
            f = $sformatf("%s%0d", f, zeros ? 0 : $urandom_range(9));
        return f;
    endfunction

    task automatic build_stamp(int y, int mo, int d, int h, int mi, int s, string frac);
        string str;
        text_buf.delete();
        str = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d%sZ", y, mo, d, h, mi, s, frac);
        for (int i = 0; i < str.len(); i++)
            text_buf.push_back(str[i]);
    endtask

    task automatic send_stamp(int y, int mo, int d, int h, int mi, int s, string frac);
        build_stamp(y, mo, d, h, mi, s, frac);
        send_text();
    endtask

    // Mostly plausible fields, with a share of out-of-range values.
    task automatic build_random_stamp();
        int y, mo, d, h, mi, s, nf;
        case ($urandom_range(3))
            0:       y = $urandom_range(9999);
            1:       y = $urandom_range(min_year_now - 2,
                                        (min_year_now > 9997) ? 9999 : min_year_now + 2);
            default: y = $urandom_range(min_year_now, 9999);
        endcase
        mo = ($urandom_range(99) < 92) ? $urandom_range(1, 12) : $urandom_range(99);
        case ($urandom_range(9))
            0:       d = $urandom_range(99);
            1, 2:    d = $urandom_range(28, 31);
            default: d = $urandom_range(1, month_length(y, (mo >= 1 && mo <= 12) ? mo : 1));
        endcase
        h = ($urandom_range(99) < 92) ? $urandom_range(23) : $urandom_range(99);
        mi = ($urandom_range(99) < 92) ? $urandom_range(59) : $urandom_range(99);
        s = ($urandom_range(99) < 92) ? $urandom_range(59) : $urandom_range(99);
        case ($urandom_range(9))
            0, 1, 2, 3: nf = 0;
            9:          nf = $urandom_range(10, 12);
            default:    nf = $urandom_range(1, 9);
        endcase
        build_stamp(y, mo, d, h, mi, s, frac_text(nf, $urandom_range(3) == 0));
    endtask

    task automatic break_text();
        int n;
        case ($urandom_range(4))
            0: text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
            1:
            begin
                n = $urandom_range(1, text_buf.size() - 1);
                while (text_buf.size() > n)
                    void'(text_buf.pop_back());
            end
            2:
            begin
                text_buf.insert($urandom_range(text_buf.size() - 1), CH_NUL);
                repeat ($urandom_range(4)) text_buf.push_back(8'($urandom_range(255)));
            end
            3: repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(255)));
            default:
            begin
                text_buf.delete();
                repeat ($urandom_range(1, 30)) text_buf.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic test_default_min_year();
        send_stamp(2023, 12, 31, 23, 59, 59, "");
        send_stamp(2024, 1, 1, 0, 0, 0, "");
    endtask

    task automatic test_calendar_limits();
        send_stamp(2024, 2, 29, 12, 0, 0, "");
        send_stamp(2025, 2, 29, 12, 0, 0, "");
        send_stamp(2100, 2, 29, 0, 0, 0, "");
        send_stamp(2400, 2, 29, 0, 0, 0, "");
        send_stamp(2024, 4, 30, 0, 0, 0, "");
        send_stamp(2024, 4, 31, 0, 0, 0, "");
        send_stamp(2024, 0, 10, 0, 0, 0, "");
        send_stamp(2024, 13, 10, 0, 0, 0, "");
        send_stamp(2024, 5, 0, 0, 0, 0, "");
        send_stamp(2024, 5, 10, 24, 0, 0, "");
        send_stamp(2024, 5, 10, 23, 60, 0, "");
        send_stamp(2024, 5, 10, 23, 59, 60, "");
        // Largest time; the nonzero fraction rounds it up to the field maximum.
        send_stamp(9999, 12, 31, 23, 59, 59, frac_text(9, 0));
        send_stamp(2024, 6, 15, 12, 30, 45, frac_text(9, 1));
        send_stamp(2024, 6, 15, 12, 30, 45, ".0001");
    endtask

    task automatic test_text_syntax();
        send_stamp(2024, 1, 1, 0, 0, 0, ".");
        send_stamp(2024, 1, 1, 0, 0, 0, frac_text(10, 0));
        build_stamp(2024, 1, 1, 0, 0, 0, "");
        text_buf.push_back(CH_DOT);
        send_text();
        build_stamp(2024, 1, 1, 0, 0, 0, ".5");
        void'(text_buf.pop_back());
        send_text();
        build_stamp(2024, 1, 1, 0, 0, 0, "");
        text_buf[4] = CH_COLON;
        send_text();
        build_stamp(2024, 1, 1, 0, 0, 0, "");
        text_buf[2] = CH_T;
        send_text();
        // A zero byte after Z ends the text; the junk after it is ignored.
        build_stamp(2024, 3, 1, 8, 0, 0, "");
        text_buf.push_back(CH_NUL);
        repeat (3) text_buf.push_back(8'($urandom_range(255)));
        send_text();
        build_stamp(2024, 3, 1, 8, 0, 0, "");
        text_buf.insert(10, CH_NUL);
        send_text();
        build_stamp(2024, 3, 1, 8, 0, 0, "");
        while (text_buf.size() > 7)
            void'(text_buf.pop_back());
        send_text();
        send_char(CH_NUL, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(CH_Z, 1'b1);
    endtask

    task automatic test_min_year_settings();
        write_min_year(EPOCH_YEAR);
        send_stamp(1970, 1, 1, 0, 0, 0, "");
        send_stamp(1969, 12, 31, 23, 59, 59, "");
        // Below the epoch year the text stays invalid whatever the setting.
        write_min_year(14'd0);
        send_stamp(0, 3, 1, 0, 0, 0, "");
        send_stamp(1969, 12, 31, 23, 59, 59, "");
        send_stamp(1970, 1, 1, 0, 0, 1, "");
        write_min_year(14'd9999);
        send_stamp(9998, 12, 31, 0, 0, 0, "");
        send_stamp(9999, 1, 1, 0, 0, 0, "");
        write_min_year(14'h3FFF);
        send_stamp(9999, 12, 31, 23, 59, 59, "");
        write_min_year(MIN_YEAR_RESET);
    endtask

    // The receiver holds off while texts keep coming, so the block fills up.
    task automatic test_output_hold();
        wait_idle();
        gaps_on = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (12)
        begin
            build_random_stamp();
            send_text();
        end
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_texts();
        int quota;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       write_min_year(EPOCH_YEAR);
                1:       write_min_year(14'($urandom_range(1970, 9999)));
                2:       write_min_year(MIN_YEAR_RESET);
                default: write_min_year(14'($urandom_range(1970, 3000)));
            endcase
            // The third phase runs with no idling on either side.
            gaps_on = (ph != 2);
            quota = chars_sent + 200;
            while (chars_sent < quota)
            begin
                build_random_stamp();
                if ($urandom_range(99) < 22)
                    break_text();
                send_text();
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic check_stamp();
        stamp_t want;
        if (pending_stamps.size() == 0)
        begin
            $error("result with no text pending: epoch_seconds %0d valid_res %0b",
                   epoch_seconds, valid_res);
            mismatches++;
        end
        else
        begin
            want = pending_stamps.pop_front();
            if (epoch_seconds !== want.epoch)
            begin
                $error("epoch_seconds: expected %0d, actual %0d", want.epoch, epoch_seconds);
                mismatches++;
            end
            if (valid_res !== want.ok)
            begin
                $error("valid_res: expected %0b, actual %0b", want.ok, valid_res);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_stamp();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_min_year();
        test_calendar_limits();
        test_text_syntax();
        test_min_year_settings();
        test_output_hold();
        test_random_texts();
        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
